// ===== hw/rtl/entity_handle_allocator_mask_table_core_assert.svh =====
// Assertion macros for the handle allocator core.
// Used by ehamt_ctrl; depends on nothing. Empty bodies when SYNTH is defined.
`ifndef ENTITY_HANDLE_ALLOCATOR_MASK_TABLE_CORE_ASSERT_SVH
`define ENTITY_HANDLE_ALLOCATOR_MASK_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
// expr must hold at every clock edge out of reset
`define EHAMT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ehamt assertion failed");
// ante implies cons in the same cycle
`define EHAMT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ehamt assertion failed");
// ante implies cons in the next cycle
`define EHAMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ehamt assertion failed");
`else
`define EHAMT_ASSERT_ALWAYS(label, clk, rst, expr)
`define EHAMT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define EHAMT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/ehamt_pkg.sv =====
// Shared constants, codes and memory request types of the handle allocator.
// No dependencies.
`default_nettype none
package ehamt_pkg;

   localparam int EntityCapacity = 1024;
   localparam int ComponentKinds = 32;

   localparam int ENTITY_W = 10;                        // handle field width
   localparam int COMP_W   = 5;                         // component field width
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 32;
   localparam int COUNT_W  = 6;                         // registered_count width
   localparam int ADDR_W   = $clog2(EntityCapacity);    // table / stack index
   localparam int DEPTH_W  = $clog2(EntityCapacity + 1);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 3'd0,
      CMD_DESTROY = 3'd1,
      CMD_ADD     = 3'd2,
      CMD_REMOVE  = 3'd3,
      CMD_HAS     = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 2'd0,
      ST_BAD_ENTITY    = 2'd1,
      ST_BAD_COMPONENT = 2'd2,
      ST_FULL          = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_REG_MASK  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_COUNT = 1'b1;

   // one table entry: live flag above the component mask
   typedef struct packed {
      logic              live;
      logic [MASK_W-1:0] mask;
   } mask_word_type;

   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] raddr;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      mask_word_type     wdata;
   } mask_req_type;

   typedef struct packed {
      logic                re;
      logic [ADDR_W-1:0]   raddr;
      logic                we;
      logic [ADDR_W-1:0]   waddr;
      logic [ADDR_W-1:0]   wdata;
   } stack_req_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ehamt_mask_mem.sv =====
// Per-handle table: live flag and component mask, one write and one
// registered read port. Depends on ehamt_pkg.
`default_nettype none
module ehamt_mask_mem (
   input  wire logic                   clock,
   input  wire ehamt_pkg::mask_req_type req,
   output ehamt_pkg::mask_word_type     rdata
);
   import ehamt_pkg::*;

   mask_word_type mem [EntityCapacity];
   mask_word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= mem[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ehamt_stack_mem.sv =====
// Free-handle stack storage, one write and one registered read port.
// Depends on ehamt_pkg.
`default_nettype none
module ehamt_stack_mem (
   input  wire logic                     clock,
   input  wire ehamt_pkg::stack_req_type  req,
   output logic [ehamt_pkg::ADDR_W-1:0]   rdata
);
   import ehamt_pkg::*;

   logic [ADDR_W-1:0] mem [EntityCapacity];
   logic [ADDR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= mem[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ehamt_ctrl.sv =====
// Command sequencer: issues table and stack reads, checks, writes back,
// and holds the result register. Depends on ehamt_pkg and the assert header.
`default_nettype none
`include "entity_handle_allocator_mask_table_core_assert.svh"
module ehamt_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ehamt_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [ehamt_pkg::ENTITY_W-1:0]   req_entity,
   input  wire logic [ehamt_pkg::COMP_W-1:0]     req_component,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ehamt_pkg::ENTITY_W-1:0]        rsp_handle,
   output logic                                  rsp_present,
   output logic [ehamt_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic                             csr_we,
   input  wire logic [ehamt_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [ehamt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ehamt_pkg::mask_req_type               mask_req,
   input  wire ehamt_pkg::mask_word_type         mask_rdata,
   output ehamt_pkg::stack_req_type              stack_req,
   input  wire logic [ehamt_pkg::ADDR_W-1:0]     stack_rdata
);
   import ehamt_pkg::*;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [ENTITY_W-1:0]   ent_ff;
   logic [COMP_W-1:0]     comp_ff;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [DEPTH_W-1:0]    hw_ff, hw_in;
   logic [MASK_W-1:0]     reg_mask_ff;
   logic [COUNT_W-1:0]    reg_count_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ENTITY_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic                  rsp_present_ff, rsp_present_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  done;
   logic                  entity_ok;
   logic                  comp_ok;
   logic [MASK_W-1:0]     bit_sel;
   logic [MASK_W-1:0]     new_mask;
   logic [DEPTH_W-1:0]    depth_dec;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   // result slot free (or being emptied) lets the command retire
   assign done      = (state_ff == S_EXEC) & (~rsp_valid_ff | rsp_ready);
   assign depth_dec = depth_ff - DEPTH_W'(1);

   assign entity_ok = (DEPTH_W'(ent_ff) < hw_ff) & mask_rdata.live;
   assign comp_ok   = (COUNT_W'(comp_ff) < reg_count_ff)
                    & ((COMP_W + 1)'(comp_ff) < (COMP_W + 1)'(ComponentKinds))
                    & reg_mask_ff[comp_ff];
   assign bit_sel   = MASK_W'(1) << comp_ff;

   always_comb begin
      // reads go out on the accept edge; data is in place during S_EXEC
      mask_req.re     = accept;
      mask_req.raddr  = ADDR_W'(req_entity);
      stack_req.re    = accept;
      stack_req.raddr = ADDR_W'(depth_dec);

      state_in        = state_ff;
      depth_in        = depth_ff;
      hw_in           = hw_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_handle_in   = rsp_handle_ff;
      rsp_present_in  = rsp_present_ff;
      rsp_status_in   = rsp_status_ff;
      mask_req.we     = 1'b0;
      mask_req.waddr  = ADDR_W'(ent_ff);
      mask_req.wdata  = '0;
      stack_req.we    = 1'b0;
      stack_req.waddr = ADDR_W'(depth_ff);
      stack_req.wdata = ADDR_W'(ent_ff);
      new_mask        = mask_rdata.mask;

      if (accept) begin
         state_in = S_EXEC;
      end

      if (done) begin
         state_in       = S_IDLE;
         rsp_valid_in   = 1'b1;
         rsp_handle_in  = ent_ff;
         rsp_present_in = 1'b0;
         rsp_status_in  = ST_OK;
         case (cmd_ff)
            CMD_CREATE: begin
               if (depth_ff != '0) begin
                  depth_in             = depth_dec;
                  mask_req.we          = 1'b1;
                  mask_req.waddr       = stack_rdata;
                  mask_req.wdata.live  = 1'b1;
                  rsp_handle_in        = ENTITY_W'(stack_rdata);
               end else if (hw_ff < DEPTH_W'(EntityCapacity)) begin
                  hw_in                = hw_ff + DEPTH_W'(1);
                  mask_req.we          = 1'b1;
                  mask_req.waddr       = ADDR_W'(hw_ff);
                  mask_req.wdata.live  = 1'b1;
                  rsp_handle_in        = ENTITY_W'(hw_ff);
               end else begin
                  rsp_handle_in        = '0;
                  rsp_status_in        = ST_FULL;
               end
            end
            CMD_DESTROY: begin
               if (!entity_ok) begin
                  rsp_status_in = ST_BAD_ENTITY;
               end else begin
                  if (depth_ff < DEPTH_W'(EntityCapacity)) begin
                     stack_req.we = 1'b1;
                     depth_in     = depth_ff + DEPTH_W'(1);
                  end
                  mask_req.we = 1'b1;   // live and mask both cleared
               end
            end
            CMD_ADD, CMD_REMOVE, CMD_HAS: begin
               if (!entity_ok) begin
                  rsp_status_in = ST_BAD_ENTITY;
               end else if (!comp_ok) begin
                  rsp_status_in = ST_BAD_COMPONENT;
               end else begin
                  if (cmd_ff == CMD_ADD) begin
                     new_mask = mask_rdata.mask | bit_sel;
                  end else if (cmd_ff == CMD_REMOVE) begin
                     new_mask = mask_rdata.mask & ~bit_sel;
                  end
                  mask_req.we         = (cmd_ff != CMD_HAS);
                  mask_req.wdata.live = 1'b1;
                  mask_req.wdata.mask = new_mask;
                  rsp_present_in      = new_mask[comp_ff];
               end
            end
            default: begin
               rsp_status_in = ST_BAD_ENTITY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         hw_ff        <= '0;
         reg_mask_ff  <= '0;
         reg_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_REG_MASK:  reg_mask_ff  <= csr_wdata;
               CSR_REG_COUNT: reg_count_ff <= csr_wdata[COUNT_W-1:0];
            endcase
         end
      end
      if (accept) begin
         cmd_ff  <= req_cmd;
         ent_ff  <= req_entity;
         comp_ff <= req_component;
      end
      rsp_handle_ff  <= rsp_handle_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_handle  = rsp_handle_ff;
   assign rsp_present = rsp_present_ff;
   assign rsp_status  = rsp_status_ff;

   // every freed handle was taken below the high-water mark
   `EHAMT_ASSERT_ALWAYS(a_depth_le_hw, clock, reset, depth_ff <= hw_ff)
   `EHAMT_ASSERT_ALWAYS(a_hw_le_cap, clock, reset, hw_ff <= DEPTH_W'(EntityCapacity))
   `EHAMT_ASSERT_IMPLIES(a_write_in_exec, clock, reset,
      mask_req.we || stack_req.we, done)
   `EHAMT_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == S_EXEC)
   `EHAMT_ASSERT_IMPLIES(a_rsp_from_exec, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == S_EXEC))

endmodule
`default_nettype wire

// ===== hw/rtl/entity_handle_allocator_mask_table_core.sv =====
// Top level of the handle allocator with per-handle component mask table.
// Depends on ehamt_pkg, ehamt_ctrl, ehamt_mask_mem and ehamt_stack_mem.
//
//   channel | dir | word contents (lsb first)                 | accepted when
//   --------+-----+-------------------------------------------+----------------------
//   req_    | in  | cmd[2:0] entity[12:3] component[17:13]    | req_tvalid & tready
//   rsp_    | out | handle[9:0] present[10] status[12:11]      | rsp_tvalid & tready
//   csr_    | in  | index 0 registered_mask, 1 registered_count| csr_we
//
// Each command is a read and a write-back: on the accept edge the mask table
// and the free stack are read, and in S_EXEC the synchronous read data is
// checked, the entry written back and the result register loaded. With one
// read-modify-write per command on the mask table, no request is taken meanwhile.
// Reset is synchronous; it empties the free stack and the high-water mark, and
// the tables need no clearing: no read data is used before its entry is written.
// A word waits in the result register while the next request word is taken;
// the command then holds in S_EXEC until the result slot frees up.
`default_nettype none
module entity_handle_allocator_mask_table_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // cmd[2:0], entity[12:3], component[17:13], zero pad [23:18]
   input  wire logic [ehamt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // handle[9:0], present[10], status[12:11], zero pad [15:13]
   output logic [ehamt_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [ehamt_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  wire logic [ehamt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ehamt_pkg::*;

   logic [CMD_W-1:0]     req_cmd;
   logic [ENTITY_W-1:0]  req_entity;
   logic [COMP_W-1:0]    req_component;
   logic [ENTITY_W-1:0]  rsp_handle;
   logic                 rsp_present;
   logic [STATUS_W-1:0]  rsp_status;
   mask_req_type         mask_req;
   mask_word_type        mask_rdata;
   stack_req_type        stack_req;
   logic [ADDR_W-1:0]    stack_rdata;

   // unpack the request word
   assign req_cmd       = req_tdata[CMD_W-1:0];
   assign req_entity    = req_tdata[CMD_W +: ENTITY_W];
   assign req_component = req_tdata[CMD_W + ENTITY_W +: COMP_W];

   // pack the result word, zero filled to the 16-bit word
   assign rsp_tdata = RSP_DATA_W'({rsp_status, rsp_present, rsp_handle});

   ehamt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_cmd       (req_cmd),
      .req_entity    (req_entity),
      .req_component (req_component),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_handle    (rsp_handle),
      .rsp_present   (rsp_present),
      .rsp_status    (rsp_status),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mask_req      (mask_req),
      .mask_rdata    (mask_rdata),
      .stack_req     (stack_req),
      .stack_rdata   (stack_rdata)
   );

   // live flag and component mask per handle
   ehamt_mask_mem u_mask_mem (
      .clock (clock),
      .req   (mask_req),
      .rdata (mask_rdata)
   );

   // LIFO of destroyed handles
   ehamt_stack_mem u_stack_mem (
      .clock (clock),
      .req   (stack_req),
      .rdata (stack_rdata)
   );

endmodule
`default_nettype wire
